>>> rtl/core/integer_to_radix_text_defines.svh
// Assertion macros for the checker file of the radix text converter
`ifndef INTEGER_TO_RADIX_TEXT_DEFINES_SVH
`define INTEGER_TO_RADIX_TEXT_DEFINES_SVH

// Require cons in the cycle after ante, idle during reset
`define ITRT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("itrt check failed");

// Require cons in the same cycle as ante, idle during reset
`define ITRT_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("itrt check failed");

`endif

>>> rtl/core/itrt_pkg.sv
// Shared types, constants and the digit-to-ASCII function of the radix text converter
`default_nettype none

package itrt_pkg;

    localparam int RADIX_W = 6;
    localparam int CHAR_W  = 7;

    localparam logic [RADIX_W-1:0] RADIX_MIN      = 6'd2;
    localparam logic [RADIX_W-1:0] RADIX_MAX      = 6'd36;
    localparam logic [RADIX_W-1:0] DECIMAL_DIGITS = 6'd10;

    localparam logic [CHAR_W-1:0] CHAR_ZERO    = 7'h30;
    localparam logic [CHAR_W-1:0] CHAR_LOWER_A = 7'h61;
    localparam logic [CHAR_W-1:0] CHAR_MINUS   = 7'h2d;
    localparam logic [CHAR_W-1:0] CHAR_NINE    = 7'h39;
    localparam logic [CHAR_W-1:0] CHAR_LOWER_Z = 7'h7a;

    // Restoring division steps done per clock in the back end
    localparam int STEPS_PER_CYCLE = 8;

    // Entries in the queue between front and back
    localparam int QUEUE_DEPTH = 2;

    typedef struct packed {
        logic               negative;
        logic [RADIX_W-1:0] radix;
    } item_ctl_t;

    function automatic logic [CHAR_W-1:0] digit_to_ascii(input logic [RADIX_W-1:0] digit);
        logic [CHAR_W-1:0] c;
        if (digit < DECIMAL_DIGITS)
        begin
            c = CHAR_ZERO + {1'b0, digit};
        end
        else
        begin
            c = CHAR_LOWER_A + {1'b0, digit - DECIMAL_DIGITS};
        end
        return c;
    endfunction

endpackage

`default_nettype wire

>>> rtl/core/itrt_if.sv
// Handshake interfaces for the number input and the character output
`default_nettype none

interface itrt_num_if import itrt_pkg::*; #(parameter int VALUE_WIDTH = 32);
    logic                          valid;
    logic                          ready;
    logic signed [VALUE_WIDTH-1:0] value;
    logic        [RADIX_W-1:0]     radix;

    modport source (output valid, output value, output radix, input ready);
    modport sink   (input valid, input value, input radix, output ready);
endinterface

interface itrt_text_if import itrt_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [CHAR_W-1:0] text_char;
    logic              last_char;

    modport source (output valid, output text_char, output last_char, input ready);
    modport sink   (input valid, input text_char, input last_char, output ready);
endinterface

`default_nettype wire

>>> rtl/core/itrt_ram.sv
// Generic single-write, single-read RAM with registered read data
`default_nettype none

module itrt_ram #(
    parameter int WIDTH = 6,
    parameter int DEPTH = 32
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write one entry, read one entry, hold read data when idle
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

>>> rtl/core/itrt_front.sv
// Front end: take a number word, clamp the radix, split sign and magnitude
`default_nettype none

module itrt_front import itrt_pkg::*; #(
    parameter int VALUE_WIDTH = 32
) (
    itrt_num_if.sink                 number,
    output logic                     push_valid,
    input  wire logic                push_ready,
    output item_ctl_t                push_ctl,
    output logic [VALUE_WIDTH-1:0]   push_mag
);

    logic [VALUE_WIDTH-1:0] value_bits;

    // Pass the handshake straight to the queue
    assign push_valid   = number.valid;
    assign number.ready = push_ready;

    // Clamp radix into the supported range and take the sign
    always_comb
    begin
        push_ctl.negative = value_bits[VALUE_WIDTH-1];
        priority if (number.radix < RADIX_MIN)
        begin
            push_ctl.radix = RADIX_MIN;
        end
        else if (number.radix > RADIX_MAX)
        begin
            push_ctl.radix = RADIX_MAX;
        end
        else
        begin
            push_ctl.radix = number.radix;
        end
    end

    // Form the unsigned magnitude, valid for the most negative value too
    assign value_bits        = number.value;
    assign push_mag          = push_ctl.negative ? (~value_bits + VALUE_WIDTH'(1)) : value_bits;

endmodule

`default_nettype wire

>>> rtl/core/itrt_queue.sv
// Short register queue decoupling the front end from the back end
`default_nettype none

module itrt_queue import itrt_pkg::*; #(
    parameter int DATA_W = 39
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              push_valid,
    output logic                   push_ready,
    input  wire logic [DATA_W-1:0] push_data,
    output logic                   pop_valid,
    input  wire logic              pop_ready,
    output logic      [DATA_W-1:0] pop_data
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    logic [DATA_W-1:0] slot_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              do_push, do_pop;

    assign push_ready = (count_reg != CNT_W'(QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = slot_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    // Advance pointers with wrap and track the fill level
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    // Hold pointers and fill level
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store the incoming word
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

>>> rtl/core/itrt_back.sv
// Back end: divide out digits into the buffer, then send the text in reverse
`default_nettype none

module itrt_back import itrt_pkg::*; #(
    parameter int VALUE_WIDTH = 32
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             pop_valid,
    output logic                                  pop_ready,
    input  wire item_ctl_t                        pop_ctl,
    input  wire logic [VALUE_WIDTH-1:0]           pop_mag,
    output logic                                  buf_wr_en,
    output logic      [$clog2(VALUE_WIDTH)-1:0]   buf_wr_addr,
    output logic      [RADIX_W-1:0]               buf_wr_data,
    output logic                                  buf_rd_en,
    output logic      [$clog2(VALUE_WIDTH)-1:0]   buf_rd_addr,
    input  wire logic [RADIX_W-1:0]               buf_rd_data,
    itrt_text_if.source                           text
);

    localparam int DIV_CYCLES = (VALUE_WIDTH + STEPS_PER_CYCLE - 1) / STEPS_PER_CYCLE;
    localparam int PAD_W      = DIV_CYCLES * STEPS_PER_CYCLE;
    localparam int CYC_W      = (DIV_CYCLES > 1) ? $clog2(DIV_CYCLES) : 1;
    localparam int ADDR_W     = $clog2(VALUE_WIDTH);
    localparam int DCNT_W     = $clog2(VALUE_WIDTH + 1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIVIDE,
        ST_SIGN,
        ST_READ,
        ST_PUT
    } state_t;

    state_t             state_reg, state_next;
    logic [PAD_W-1:0]   quo_reg, quo_next;
    logic [RADIX_W-1:0] rem_reg, rem_next;
    logic [RADIX_W-1:0] radix_reg, radix_next;
    logic               neg_reg, neg_next;
    logic [CYC_W-1:0]   cyc_reg, cyc_next;
    logic [DCNT_W-1:0]  dcount_reg, dcount_next;
    logic               out_valid_reg, out_valid_next;
    logic [CHAR_W-1:0]  out_char_reg, out_char_next;
    logic               out_last_reg, out_last_next;

    logic [PAD_W-1:0]   step_quo;
    logic [RADIX_W-1:0] step_rem;
    logic [RADIX_W:0]   trial;
    logic [DCNT_W-1:0]  dcount_inc;
    logic [DCNT_W-1:0]  rd_index;
    logic               out_free;

    // Run a group of restoring division steps on the padded magnitude
    always_comb
    begin
        step_quo = quo_reg;
        step_rem = rem_reg;
        trial    = '0;
        for (int i = 0; i < STEPS_PER_CYCLE; i++)
        begin
            trial    = {step_rem, step_quo[PAD_W-1]};
            step_quo = {step_quo[PAD_W-2:0], 1'b0};
            if (trial >= {1'b0, radix_reg})
            begin
                trial       = trial - {1'b0, radix_reg};
                step_quo[0] = 1'b1;
            end
            step_rem = trial[RADIX_W-1:0];
        end
    end

    assign dcount_inc  = dcount_reg + DCNT_W'(1);
    assign out_free    = !out_valid_reg || text.ready;
    assign rd_index    = (state_reg == ST_READ) ? (dcount_reg - DCNT_W'(1))
                                                : (dcount_reg - DCNT_W'(2));
    assign buf_rd_addr = rd_index[ADDR_W-1:0];
    assign buf_wr_addr = dcount_reg[ADDR_W-1:0];
    assign buf_wr_data = step_rem;

    // Sequence one number: divide, optional sign, then digits in reverse
    always_comb
    begin
        state_next     = state_reg;
        quo_next       = quo_reg;
        rem_next       = rem_reg;
        radix_next     = radix_reg;
        neg_next       = neg_reg;
        cyc_next       = cyc_reg;
        dcount_next    = dcount_reg;
        out_valid_next = out_valid_reg && !text.ready;
        out_char_next  = out_char_reg;
        out_last_next  = out_last_reg;
        pop_ready      = 1'b0;
        buf_wr_en      = 1'b0;
        buf_rd_en      = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                pop_ready = 1'b1;
                if (pop_valid)
                begin
                    quo_next    = PAD_W'(pop_mag);
                    rem_next    = '0;
                    radix_next  = pop_ctl.radix;
                    neg_next    = pop_ctl.negative;
                    cyc_next    = '0;
                    dcount_next = '0;
                    state_next  = ST_DIVIDE;
                end
            end
            ST_DIVIDE:
            begin
                quo_next = step_quo;
                if (cyc_reg == CYC_W'(DIV_CYCLES - 1))
                begin
                    // Digit complete: store it and restart on the quotient
                    buf_wr_en   = 1'b1;
                    dcount_next = dcount_inc;
                    rem_next    = '0;
                    cyc_next    = '0;
                    if ((step_quo == '0) || (dcount_inc == DCNT_W'(VALUE_WIDTH)))
                    begin
                        state_next = neg_reg ? ST_SIGN : ST_READ;
                    end
                end
                else
                begin
                    rem_next = step_rem;
                    cyc_next = cyc_reg + CYC_W'(1);
                end
            end
            ST_SIGN:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_char_next  = CHAR_MINUS;
                    out_last_next  = 1'b0;
                    state_next     = ST_READ;
                end
            end
            ST_READ:
            begin
                buf_rd_en  = 1'b1;
                state_next = ST_PUT;
            end
            ST_PUT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_char_next  = digit_to_ascii(buf_rd_data);
                    out_last_next  = (dcount_reg == DCNT_W'(1));
                    dcount_next    = dcount_reg - DCNT_W'(1);
                    if (dcount_reg == DCNT_W'(1))
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        buf_rd_en = 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Hold state and the output word
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            quo_reg       <= '0;
            rem_reg       <= '0;
            radix_reg     <= RADIX_MIN;
            neg_reg       <= 1'b0;
            cyc_reg       <= '0;
            dcount_reg    <= '0;
            out_valid_reg <= 1'b0;
            out_char_reg  <= CHAR_ZERO;
            out_last_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            quo_reg       <= quo_next;
            rem_reg       <= rem_next;
            radix_reg     <= radix_next;
            neg_reg       <= neg_next;
            cyc_reg       <= cyc_next;
            dcount_reg    <= dcount_next;
            out_valid_reg <= out_valid_next;
            out_char_reg  <= out_char_next;
            out_last_reg  <= out_last_next;
        end
    end

    assign text.valid     = out_valid_reg;
    assign text.text_char = out_char_reg;
    assign text.last_char = out_last_reg;

endmodule

`default_nettype wire

>>> rtl/core/integer_to_radix_text.sv
// Top level of the signed integer to radix text converter
//
//   channel  dir  payload                      handshake
//   number   in   value (signed), radix (6b)   valid / ready
//   text     out  text_char (7b), last_char    valid / ready
//
// The back end takes a number from the queue; each digit is then divided out in the
// shared restoring divider (8 quotient bits per clock); then the minus sign is sent
// when negative, the first buffer read is made, and the digits are sent, one per
// cycle while the text channel is not stalled.
// Reset is asynchronous, active low; no clearing pass is needed.
// A two-word queue lets the next number wait while the back end is busy, and
// the registered output word holds each character while text is stalled.
`default_nettype none

module integer_to_radix_text import itrt_pkg::*; #(
    parameter int VALUE_WIDTH = 32
) (
    input  wire logic   clk,
    input  wire logic   rst_n,
    itrt_num_if.sink    number,
    itrt_text_if.source text
);

    localparam int ADDR_W = $clog2(VALUE_WIDTH);
    localparam int QDATA_W = $bits(item_ctl_t) + VALUE_WIDTH;

    logic                   push_valid, push_ready;
    item_ctl_t              push_ctl;
    logic [VALUE_WIDTH-1:0] push_mag;
    logic [QDATA_W-1:0]     push_data;

    logic                   pop_valid, pop_ready;
    item_ctl_t              pop_ctl;
    logic [VALUE_WIDTH-1:0] pop_mag;
    logic [QDATA_W-1:0]     pop_data;

    logic                   buf_wr_en, buf_rd_en;
    logic [ADDR_W-1:0]      buf_wr_addr, buf_rd_addr;
    logic [RADIX_W-1:0]     buf_wr_data, buf_rd_data;

    itrt_front #(.VALUE_WIDTH(VALUE_WIDTH)) u_front (
        .number     (number),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_ctl   (push_ctl),
        .push_mag   (push_mag)
    );

    // Pack classified number for the queue
    assign push_data          = {push_ctl, push_mag};
    assign {pop_ctl, pop_mag} = pop_data;

    itrt_queue #(.DATA_W(QDATA_W)) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data)
    );

    itrt_ram #(.WIDTH(RADIX_W), .DEPTH(VALUE_WIDTH)) u_digit_buf (
        .clk     (clk),
        .wr_en   (buf_wr_en),
        .wr_addr (buf_wr_addr),
        .wr_data (buf_wr_data),
        .rd_en   (buf_rd_en),
        .rd_addr (buf_rd_addr),
        .rd_data (buf_rd_data)
    );

    itrt_back #(.VALUE_WIDTH(VALUE_WIDTH)) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .pop_valid   (pop_valid),
        .pop_ready   (pop_ready),
        .pop_ctl     (pop_ctl),
        .pop_mag     (pop_mag),
        .buf_wr_en   (buf_wr_en),
        .buf_wr_addr (buf_wr_addr),
        .buf_wr_data (buf_wr_data),
        .buf_rd_en   (buf_rd_en),
        .buf_rd_addr (buf_rd_addr),
        .buf_rd_data (buf_rd_data),
        .text        (text)
    );

endmodule

`default_nettype wire

>>> rtl/core/itrt_checker.sv
// Port-level checks on the text output of the converter, bound to the top level
`default_nettype none

`include "integer_to_radix_text_defines.svh"

module itrt_checker import itrt_pkg::*; (
    input wire logic              clk,
    input wire logic              rst_n,
    input wire logic              valid,
    input wire logic              ready,
    input wire logic [CHAR_W-1:0] text_char,
    input wire logic              last_char
);

    logic char_legal;

    // Accept only minus, decimal digits and lower-case letters
    assign char_legal = (text_char == CHAR_MINUS)
                     || ((text_char >= CHAR_ZERO) && (text_char <= CHAR_NINE))
                     || ((text_char >= CHAR_LOWER_A) && (text_char <= CHAR_LOWER_Z));

    `ITRT_ASSERT_NEXT(a_valid_hold, clk, rst_n, valid && !ready, valid)
    `ITRT_ASSERT_NEXT(a_word_hold, clk, rst_n, valid && !ready, $stable(text_char) && $stable(last_char))
    `ITRT_ASSERT_NOW(a_char_legal, clk, rst_n, valid, char_legal)
    `ITRT_ASSERT_NOW(a_minus_not_last, clk, rst_n, valid && (text_char == CHAR_MINUS), !last_char)

endmodule

bind integer_to_radix_text itrt_checker u_itrt_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .valid     (text.valid),
    .ready     (text.ready),
    .text_char (text.text_char),
    .last_char (text.last_char)
);

`default_nettype wire

>>> tb/sv/tb.sv
// Testbench for the signed integer to radix text converter
`default_nettype none

module tb import itrt_pkg::*; ();

    localparam int VALUE_W      = 32;
    localparam int RANDOM_ITEMS = 96;
    localparam int DRAIN_LIMIT  = 200000;
    localparam int SETTLE_CYCLES = 300;

    // Expected text of every accepted number, one entry per character word
    class char_scoreboard;
        typedef struct packed {
            logic [CHAR_W-1:0] text_char;
            logic              last_char;
        } text_word_t;

        text_word_t expected_chars[$];
        int         mismatches;

        function new();
            mismatches = 0;
        endfunction

        task report_mismatch(input string msg);
            $display("MISMATCH at %0t: %s", $realtime, msg);
            mismatches++;
        endtask

        // Convert one accepted number and queue its characters
        function void note_number(input logic signed [VALUE_W-1:0] value,
                                  input logic [RADIX_W-1:0] radix);
            logic [RADIX_W-1:0] base;
            logic [VALUE_W-1:0] magnitude;
            logic [RADIX_W-1:0] digits[$];
            logic [RADIX_W-1:0] d;
            text_word_t         w;
            int                 i;
            base = radix;
            if (base < RADIX_MIN)
                base = RADIX_MIN;
            if (base > RADIX_MAX)
                base = RADIX_MAX;
            // Take the magnitude as unsigned so the most negative value survives
            magnitude = value;
            if (value[VALUE_W-1])
                magnitude = -magnitude;
            do
            begin
                d = RADIX_W'(magnitude % base);
                digits.push_back(d);
                magnitude = magnitude / base;
            end
            while (magnitude != 0);
            if (value[VALUE_W-1])
            begin
                w.text_char = CHAR_MINUS;
                w.last_char = 1'b0;
                expected_chars.push_back(w);
            end
            // Emit digits most significant first
            for (i = digits.size() - 1; i >= 0; i--)
            begin
                if (digits[i] < DECIMAL_DIGITS)
                    w.text_char = CHAR_ZERO + CHAR_W'(digits[i]);
                else
                    w.text_char = CHAR_LOWER_A + CHAR_W'(digits[i] - DECIMAL_DIGITS);
                w.last_char = (i == 0);
                expected_chars.push_back(w);
            end
        endfunction

        // Compare one accepted character word with the oldest expectation
        task check_char(input logic [CHAR_W-1:0] text_char, input logic last_char);
            text_word_t w;
            if (expected_chars.size() == 0)
            begin
                report_mismatch($sformatf("unexpected char %h last %b", text_char, last_char));
            end
            else
            begin
                w = expected_chars.pop_front();
                if (text_char !== w.text_char)
                    report_mismatch($sformatf("text_char %h, want %h", text_char, w.text_char));
                if (last_char !== w.last_char)
                    report_mismatch($sformatf("last_char %b, want %b (char %h)",
                                              last_char, w.last_char, w.text_char));
            end
        endtask

        function int pending();
            return expected_chars.size();
        endfunction
    endclass

    logic clk;
    logic rst_n;

    itrt_num_if #(.VALUE_WIDTH(VALUE_W)) num_if ();
    itrt_text_if                         text_if ();

    char_scoreboard sb = new();

    integer_to_radix_text #(.VALUE_WIDTH(VALUE_W)) i_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .number (num_if),
        .text   (text_if)
    );

    // Clock
    initial clk = 1'b0;
    always #10 clk = ~clk;

    // Hard stop for a hung run
    initial
    begin
        #20000000;
        $display("Verification failed");
        $finish;
    end

    // Receiver stall pattern: switch between four random ready modes
    int stall_mode  = 0;
    int stall_left  = 0;
    int stall_phase = 0;

    always @(negedge clk)
    begin
        if (stall_left == 0)
        begin
            stall_mode <= $urandom_range(0, 3);
            stall_left <= $urandom_range(20, 120);
        end
        else
        begin
            stall_left <= stall_left - 1;
        end
        stall_phase <= (stall_phase == 24) ? 0 : stall_phase + 1;
        case (stall_mode)
            0: text_if.ready <= 1'b1;
            1: text_if.ready <= ($urandom_range(0, 3) != 0);
            2: text_if.ready <= ($urandom_range(0, 3) == 0);
            default: text_if.ready <= (stall_phase < 7);
        endcase
    end

    // Check every accepted character word
    always @(posedge clk)
    begin
        if (rst_n && text_if.valid && text_if.ready)
            sb.check_char(text_if.text_char, text_if.last_char);
    end

    // Present one number word and hold it until accepted; return at the next falling edge
    task automatic send_number(input logic signed [VALUE_W-1:0] value,
                               input logic [RADIX_W-1:0] radix);
        num_if.valid <= 1'b1;
        num_if.value <= value;
        num_if.radix <= radix;
        @(posedge clk);
        while (!num_if.ready)
            @(posedge clk);
        sb.note_number(value, radix);
        @(negedge clk);
    endtask

    // Drop valid for a gap set by n
    task automatic idle_sender(input int n);
        if (n > 0)
        begin
            num_if.valid <= 1'b0;
            repeat (n) @(negedge clk);
        end
    endtask

    // Drop valid and hold off until every expected character has come or the drain limit is hit
    task automatic wait_text_drained();
        int cycles;
        cycles = 0;
        num_if.valid <= 1'b0;
        @(negedge clk);
        while (sb.pending() != 0 && cycles < DRAIN_LIMIT)
        begin
            @(negedge clk);
            cycles++;
        end
    endtask

    logic signed [VALUE_W-1:0] rand_value;
    logic [RADIX_W-1:0]        rand_radix;
    int                        sent;
    int                        burst;

    initial
    begin
        rst_n        = 1'b0;
        num_if.valid = 1'b0;
        num_if.value = '0;
        num_if.radix = '0;
        repeat (11) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed: zero, extremes, clamped radix and digit boundaries
        send_number(32'sd0, 6'd10);
        send_number(32'sd1, 6'd2);
        send_number(-32'sd1, 6'd2);
        send_number(32'sh7fffffff, 6'd10);
        send_number(32'sh80000000, 6'd10);
        send_number(32'sh80000000, 6'd2);
        send_number(32'sh7fffffff, 6'd2);
        send_number(32'sh7fffffff, 6'd36);
        send_number(32'sh80000000, 6'd36);
        idle_sender(3);
        send_number(32'sd255, 6'd0);
        send_number(-32'sd255, 6'd1);
        send_number(32'sd1295, 6'd37);
        send_number(32'sd1295, 6'd63);
        send_number(32'sd0, 6'd63);
        send_number(32'sd0, 6'd0);
        send_number(32'sd35, 6'd36);
        send_number(32'sd36, 6'd36);
        send_number(32'sd10, 6'd16);
        send_number(-32'sd1, 6'd16);
        send_number(32'sd9, 6'd10);
        send_number(32'sd12345, 6'd7);
        send_number(-32'sd987654321, 6'd10);
        send_number(32'sh80000001, 6'd3);
        send_number(32'shffffffff, 6'd63);
        wait_text_drained();

        // Random: bursts of numbers with random gaps
        sent = 0;
        while (sent < RANDOM_ITEMS)
        begin
            burst = $urandom_range(1, 8);
            repeat (burst)
            begin
                case ($urandom_range(0, 9))
                    0, 1, 2, 3: rand_value = $urandom;
                    4, 5: rand_value = $urandom_range(0, 200);
                    6: rand_value = -$signed({1'b0, 31'($urandom_range(1, 200))});
                    7:
                    begin
                        case ($urandom_range(0, 3))
                            0: rand_value = 32'sd0;
                            1: rand_value = -32'sd1;
                            2: rand_value = 32'sh7fffffff;
                            default: rand_value = 32'sh80000000;
                        endcase
                    end
                    default:
                    begin
                        rand_value = $urandom >> $urandom_range(0, 31);
                        if ($urandom_range(0, 1))
                            rand_value = -rand_value;
                    end
                endcase
                if ($urandom_range(0, 9) < 7)
                    rand_radix = RADIX_W'($urandom_range(2, 36));
                else
                    rand_radix = RADIX_W'($urandom_range(0, 63));
                send_number(rand_value, rand_radix);
                sent++;
                if (sent == RANDOM_ITEMS / 2)
                    wait_text_drained();
            end
            if ($urandom_range(0, 2) != 0)
                idle_sender($urandom_range(1, 40));
        end

        // Wait for the tail of the text, then let the block settle
        wait_text_drained();
        repeat (SETTLE_CYCLES) @(negedge clk);
        if (sb.pending() != 0)
            sb.report_mismatch($sformatf("%0d expected chars never came", sb.pending()));

        if (sb.mismatches == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

`default_nettype wire

>>> files.f
+incdir+rtl/core
rtl/core/itrt_pkg.sv
rtl/core/itrt_if.sv
rtl/core/itrt_ram.sv
rtl/core/itrt_front.sv
rtl/core/itrt_queue.sv
rtl/core/itrt_back.sv
rtl/core/integer_to_radix_text.sv
rtl/core/itrt_checker.sv
tb/sv/tb.sv
